>>> src/sbs_pkg.sv
// Package: types, constants and sine table for the sprite setup engine.
`default_nettype none
package sbs_pkg;
    localparam int SLOTS = 8;
    localparam int MAX_SPRITES = 1024;
    localparam int SLOT_W = 3;
    localparam int SCNT_W = 4;
    localparam int SPR_W = 11;

    localparam logic FUNC_SPRITE = 1'b0;
    localparam logic FUNC_FLUSH  = 1'b1;

    typedef struct packed {
        logic               func;
        logic        [15:0] tex_key;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic        [23:0] size_w;
        logic        [23:0] size_h;
        logic        [15:0] angle;
        logic        [15:0] uv_u;
        logic        [15:0] uv_v;
        logic        [15:0] uv_du;
        logic        [15:0] uv_dv;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] vtx_x;
        logic signed [31:0] vtx_y;
        logic        [16:0] tex_u;
        logic        [16:0] tex_v;
        logic        [2:0]  slot;
        logic               flush_before;
        logic               last;
    } t_out_word;

    // Quarter-wave sine, Q1.14.
    function automatic logic [14:0] sin_rom(input logic [6:0] k);
        logic [14:0] r;
        unique case (k)
            7'd0: r = 15'd0;      7'd1: r = 15'd402;    7'd2: r = 15'd804;
            7'd3: r = 15'd1205;   7'd4: r = 15'd1606;   7'd5: r = 15'd2006;
            7'd6: r = 15'd2404;   7'd7: r = 15'd2801;   7'd8: r = 15'd3196;
            7'd9: r = 15'd3590;   7'd10: r = 15'd3981;  7'd11: r = 15'd4370;
            7'd12: r = 15'd4756;  7'd13: r = 15'd5139;  7'd14: r = 15'd5520;
            7'd15: r = 15'd5897;  7'd16: r = 15'd6270;  7'd17: r = 15'd6639;
            7'd18: r = 15'd7005;  7'd19: r = 15'd7366;  7'd20: r = 15'd7723;
            7'd21: r = 15'd8076;  7'd22: r = 15'd8423;  7'd23: r = 15'd8765;
            7'd24: r = 15'd9102;  7'd25: r = 15'd9434;  7'd26: r = 15'd9760;
            7'd27: r = 15'd10080; 7'd28: r = 15'd10394; 7'd29: r = 15'd10702;
            7'd30: r = 15'd11003; 7'd31: r = 15'd11297; 7'd32: r = 15'd11585;
            7'd33: r = 15'd11866; 7'd34: r = 15'd12140; 7'd35: r = 15'd12406;
            7'd36: r = 15'd12665; 7'd37: r = 15'd12916; 7'd38: r = 15'd13160;
            7'd39: r = 15'd13395; 7'd40: r = 15'd13623; 7'd41: r = 15'd13842;
            7'd42: r = 15'd14053; 7'd43: r = 15'd14256; 7'd44: r = 15'd14449;
            7'd45: r = 15'd14635; 7'd46: r = 15'd14811; 7'd47: r = 15'd14978;
            7'd48: r = 15'd15137; 7'd49: r = 15'd15286; 7'd50: r = 15'd15426;
            7'd51: r = 15'd15557; 7'd52: r = 15'd15679; 7'd53: r = 15'd15791;
            7'd54: r = 15'd15893; 7'd55: r = 15'd15986; 7'd56: r = 15'd16069;
            7'd57: r = 15'd16143; 7'd58: r = 15'd16207; 7'd59: r = 15'd16261;
            7'd60: r = 15'd16305; 7'd61: r = 15'd16340; 7'd62: r = 15'd16364;
            7'd63: r = 15'd16379; 7'd64: r = 15'd16384;
            default: r = 15'd0;
        endcase
        return r;
    endfunction

    // Signed sine of an 8-bit binary angle, Q1.14.
    function automatic logic signed [15:0] sin_of(input logic [7:0] idx);
        logic [14:0] m;
        logic [6:0]  j;
        j = {1'b0, idx[5:0]};
        m = idx[6] ? sin_rom(7'd64 - j) : sin_rom(j);
        return idx[7] ? -$signed({1'b0, m}) : $signed({1'b0, m});
    endfunction
endpackage
`default_nettype wire

>>> src/sbs_slot_search.sv
// Slot table with one-entry-per-cycle texture search and append.
`default_nettype none
module sbs_slot_search
    import sbs_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic              i_clear,
    input  wire logic [15:0]       i_tex,
    output logic                   o_done,
    output logic [SLOT_W-1:0]      o_slot
);
    logic [15:0]       r_table [SLOTS];
    logic [SCNT_W-1:0] r_count, n_count;
    logic [SCNT_W-1:0] r_idx, n_idx;
    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic              wr_en;

    // Step one entry per cycle; append on a miss.
    always_comb begin
        n_count = r_count;
        n_idx   = r_idx;
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_slot  = r_slot;
        wr_en   = 1'b0;
        if (i_clear) begin
            n_count = '0;
        end
        if (i_start) begin
            n_busy = 1'b1;
            n_idx  = '0;
        end else if (r_busy) begin
            if (r_idx >= r_count) begin
                wr_en   = 1'b1;
                n_slot  = r_idx[SLOT_W-1:0];
                n_count = r_count + 1'b1;
                n_busy  = 1'b0;
                n_done  = 1'b1;
            end else if (r_table[r_idx[SLOT_W-1:0]] == i_tex) begin
                n_slot = r_idx[SLOT_W-1:0];
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_idx = r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_count <= n_count;
            r_busy  <= n_busy;
            r_done  <= n_done;
            r_idx   <= n_idx;
        end
        r_slot <= n_slot;
        if (wr_en) begin
            r_table[r_idx[SLOT_W-1:0]] <= i_tex;
        end
    end

    // Full table shows as an internal count at SLOTS; caller flushes first.
    assign o_done = r_done;
    assign o_slot = r_slot;
endmodule
`default_nettype wire

>>> src/sbs_rotate.sv
// Shared corner rotate unit: two multiplies then sum, round and translate.
`default_nettype none
module sbs_rotate
    import sbs_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic [24:0]        i_a,
    input  wire logic [24:0]        i_b,
    input  wire logic signed [15:0] i_ca,
    input  wire logic signed [15:0] i_cb,
    input  wire logic [31:0]        i_pos,
    output logic [31:0]             o_res
);
    logic signed [41:0] r_pa, r_pb;
    logic signed [42:0] sum;

    always_ff @(posedge i_clk) begin
        r_pa <= 42'($signed(i_a)) * 42'(i_ca);
        r_pb <= 42'($signed(i_b)) * 42'(i_cb);
    end

    // floor((a*ca + b*cb + 32) / 64), then add origin modulo 2^32.
    assign sum   = 43'(r_pa) + 43'(r_pb) + 43'sd32;
    assign o_res = i_pos + sum[37:6];
endmodule
`default_nettype wire

>>> src/sprite_batch_setup_with_slots_top.sv
// Top level: sequencer for batch flush, slot search and four vertex passes.
// Sequence: a sprite is launched into the slot search, which steps through the table until a hit
// or an append, then each vertex goes through one shared rotate unit in MUL, SUMX, SUMY and OUT.
// Items are taken one at a time: o_stall stays high until all four vertices of a sprite have left,
// and output stall holds the OUT state; end-of-frame items give no word.
// Reset: synchronous active low; clears batch counts and sequencer, slot table is left as is.
`default_nettype none
module sprite_batch_setup_with_slots_top
    import sbs_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_stall,
    input  wire t_in_word  i_data,
    output logic           o_valid,
    input  wire logic      i_stall,
    output t_out_word      o_data
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SRCH = 3'd1;
    localparam logic [2:0] ST_WAIT = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_SUMX = 3'd4;
    localparam logic [2:0] ST_SUMY = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    logic [2:0]        r_state, n_state;
    t_in_word          r_in;
    logic [SPR_W-1:0]  r_spr;
    logic [SCNT_W-1:0] r_scnt;
    logic              r_flush;
    logic [1:0]        r_k;
    logic [SLOT_W-1:0] r_slot;
    logic signed [15:0] r_sin, r_cos;
    logic [31:0]       r_x;
    logic              r_valid;
    t_out_word         r_out;

    logic              start, clear, s_done, accept, sel_y;
    logic [SLOT_W-1:0] s_slot;
    logic [24:0]       cx, cy, ma, mb;
    logic signed [15:0] ca, cb;
    logic [31:0]       rot;

    assign o_stall = (r_state != ST_IDLE);
    assign accept  = i_valid && !o_stall;

    // Flush on a full sprite batch or a full slot table, or on end of frame.
    always_comb begin
        clear = 1'b0;
        start = 1'b0;
        if (accept) begin
            if (i_data.func == FUNC_FLUSH) begin
                clear = 1'b1;
            end else begin
                start = 1'b1;
                clear = (r_spr >= SPR_W'(MAX_SPRITES)) || (r_scnt >= SCNT_W'(SLOTS));
            end
        end
    end

    sbs_slot_search u_srch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_clear (clear),
        .i_tex   (r_state == ST_IDLE ? i_data.tex_key : r_in.tex_key),
        .o_done  (s_done),
        .o_slot  (s_slot)
    );

    // Corner k: x is w for corners 1 and 2, y is h for corners 2 and 3.
    assign cx = (r_k == 2'd1 || r_k == 2'd2) ? {1'b0, r_in.size_w} : '0;
    assign cy = r_k[1] ? {1'b0, r_in.size_h} : '0;
    // Load x products in ST_MUL, then hold y products until the vertex leaves.
    assign sel_y = (r_state == ST_SUMX) || (r_state == ST_SUMY) || (r_state == ST_OUT);
    // x = cx*cos - cy*sin ; y = cx*sin + cy*cos
    assign ma = cx;
    assign mb = cy;
    assign ca = sel_y ? r_sin : r_cos;
    assign cb = sel_y ? r_cos : -r_sin;

    sbs_rotate u_rot (
        .i_clk (i_clk),
        .i_a   (ma),
        .i_b   (mb),
        .i_ca  (ca),
        .i_cb  (cb),
        .i_pos (r_state == ST_SUMX ? r_in.pos_x : r_in.pos_y),
        .o_res (rot)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (start) n_state = ST_SRCH;
            ST_SRCH: n_state = ST_WAIT;
            ST_WAIT: if (s_done) n_state = ST_MUL;
            ST_MUL:  n_state = ST_SUMX;
            ST_SUMX: n_state = ST_SUMY;
            ST_SUMY: n_state = ST_OUT;
            ST_OUT:  if (!(r_valid && i_stall)) n_state = (r_k == 2'd3) ? ST_IDLE : ST_MUL;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_spr   <= '0;
            r_scnt  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_OUT && !(r_valid && i_stall)) r_valid <= 1'b1;
            else if (r_valid && !i_stall) r_valid <= 1'b0;
            if (clear) begin
                r_spr  <= '0;
                r_scnt <= '0;
            end
            if (r_state == ST_WAIT && s_done) begin
                r_spr <= r_spr + 1'b1;
                // Track table fill alongside the search unit.
                if (s_slot == r_scnt[SLOT_W-1:0] && r_scnt < SCNT_W'(SLOTS))
                    r_scnt <= r_scnt + 1'b1;
            end
        end
        if (accept) begin
            r_in    <= i_data;
            r_flush <= clear;
            r_k     <= 2'd0;
            r_sin   <= sin_of(i_data.angle[15:8]);
            r_cos   <= sin_of(i_data.angle[15:8] + 8'd64);
        end
        if (r_state == ST_WAIT && s_done) r_slot <= s_slot;
        // Hold the x result while the multiplier is reloaded for y.
        if (r_state == ST_SUMX) r_x <= rot;
        if (r_state == ST_OUT && !(r_valid && i_stall)) begin
            r_out.vtx_x        <= r_x;
            r_out.vtx_y        <= rot;
            r_out.tex_u        <= (r_k == 2'd1 || r_k == 2'd2) ?
                                  17'(r_in.uv_u) + 17'(r_in.uv_du) : 17'(r_in.uv_u);
            r_out.tex_v        <= r_k[1] ? 17'(r_in.uv_v) + 17'(r_in.uv_dv) : 17'(r_in.uv_v);
            r_out.slot         <= r_slot;
            r_out.flush_before <= r_flush && (r_k == 2'd0);
            r_out.last         <= (r_k == 2'd3);
            r_k                <= r_k + 1'b1;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_out;
endmodule
`default_nettype wire
